// ===== design/rhc_pkg.sv =====
package rhc_pkg;

	// Fixed-point formats of the converter.
	localparam int CHAN_W        = 8;
	localparam int HUE_W         = 13;
	localparam int SAT_W         = 16;
	localparam int HUE_FRAC_BITS = 4;
	localparam int SAT_BITS      = 16;

	// One sector of the hue circle and the whole circle, in hue units.
	localparam int HUE_SECTOR = 60 * (2 ** HUE_FRAC_BITS);
	localparam int HUE_CIRCLE = 6 * HUE_SECTOR;
	localparam int SAT_MAX    = (2 ** SAT_BITS) - 1;

	// Restoring divider geometry. The divisor is twice an 8-bit value, and every
	// numerator fed to the divider stays below divisor * 2^DIV_Q_W.
	localparam int DIV_Q_W = SAT_BITS;
	localparam int DIV_D_W = CHAN_W + 1;
	localparam int DIV_N_W = DIV_Q_W + DIV_D_W;

	localparam int FRONT_STAGES = 3;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [SAT_W-1:0]  saturation;
		logic [CHAN_W-1:0] brightness;
	} hsv_t;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	typedef struct packed {
		logic [HUE_W-1:0] offset;
		logic             neg;
		logic             gray;
	} hue_side_t;

	typedef struct packed {
		logic              black;
		logic [CHAN_W-1:0] brightness;
	} sat_side_t;

endpackage

// ===== design/rhc_if.sv =====
interface rhc_pixel_if;
	import rhc_pkg::*;

	logic   valid;
	logic   ready;
	pixel_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rhc_hsv_if;
	import rhc_pkg::*;

	logic valid;
	logic ready;
	hsv_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/rhc_front.sv =====
module rhc_front (
	input  logic                            clk,
	input  logic [rhc_pkg::FRONT_STAGES-1:0] ld,
	input  rhc_pkg::pixel_t                 pix,
	output logic [rhc_pkg::DIV_N_W-1:0]     n_hue,
	output logic [rhc_pkg::DIV_D_W-1:0]     d_hue,
	output logic [rhc_pkg::DIV_N_W-1:0]     n_sat,
	output logic [rhc_pkg::DIV_D_W-1:0]     d_sat,
	output rhc_pkg::hue_side_t              hue_side,
	output rhc_pkg::sat_side_t              sat_side
);
	import rhc_pkg::*;

	sector_t           sect_c;
	logic [CHAN_W-1:0] mx_c, mn_c, mn_rg_c, opa_c, opb_c;

	sector_t           sect_s1;
	logic [CHAN_W-1:0] mx_s1, mn_s1, opa_s1, opb_s1;

	sector_t           sect_s2;
	logic [CHAN_W-1:0] mx_s2, delta_s2, mag_s2;
	logic              neg_s2;

	logic [HUE_W-1:0]  offset_c;

	logic [DIV_N_W-1:0] n_hue_s3, n_sat_s3;
	logic [DIV_D_W-1:0] d_hue_s3, d_sat_s3;
	hue_side_t          hue_side_s3;
	sat_side_t          sat_side_s3;

	// Largest channel picks the sector; red wins ties, then green.
	always_comb begin
		if (pix.red >= pix.green && pix.red >= pix.blue) begin
			sect_c = SECT_RED;
			mx_c   = pix.red;
			opa_c  = pix.green;
			opb_c  = pix.blue;
		end else if (pix.green >= pix.blue) begin
			sect_c = SECT_GREEN;
			mx_c   = pix.green;
			opa_c  = pix.blue;
			opb_c  = pix.red;
		end else begin
			sect_c = SECT_BLUE;
			mx_c   = pix.blue;
			opa_c  = pix.red;
			opb_c  = pix.green;
		end
		mn_rg_c = (pix.red <= pix.green) ? pix.red : pix.green;
		mn_c    = (mn_rg_c <= pix.blue) ? mn_rg_c : pix.blue;
	end

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			sect_s1 <= sect_c;
			mx_s1   <= mx_c;
			mn_s1   <= mn_c;
			opa_s1  <= opa_c;
			opb_s1  <= opb_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			sect_s2  <= sect_s1;
			mx_s2    <= mx_s1;
			delta_s2 <= mx_s1 - mn_s1;
			neg_s2   <= opa_s1 < opb_s1;
			mag_s2   <= (opa_s1 < opb_s1) ? (opb_s1 - opa_s1) : (opa_s1 - opb_s1);
		end
	end

	always_comb begin
		case (sect_s2)
			SECT_RED:   offset_c = '0;
			SECT_GREEN: offset_c = HUE_W'(2 * HUE_SECTOR);
			SECT_BLUE:  offset_c = HUE_W'(4 * HUE_SECTOR);
			default:    offset_c = '0;
		endcase
	end

	// Numerators carry the half-divisor term so the quotient comes out rounded.
	always_ff @(posedge clk) begin
		if (ld[2]) begin
			n_hue_s3 <= DIV_N_W'(2 * HUE_SECTOR) * DIV_N_W'(mag_s2) + DIV_N_W'(delta_s2);
			d_hue_s3 <= {delta_s2, 1'b0};
			n_sat_s3 <= DIV_N_W'(2 * SAT_MAX) * DIV_N_W'(delta_s2) + DIV_N_W'(mx_s2);
			d_sat_s3 <= {mx_s2, 1'b0};
			hue_side_s3.offset <= offset_c;
			hue_side_s3.neg    <= neg_s2;
			hue_side_s3.gray   <= (delta_s2 == '0);
			sat_side_s3.black      <= (mx_s2 == '0);
			sat_side_s3.brightness <= mx_s2;
		end
	end

	assign n_hue    = n_hue_s3;
	assign d_hue    = d_hue_s3;
	assign n_sat    = n_sat_s3;
	assign d_sat    = d_sat_s3;
	assign hue_side = hue_side_s3;
	assign sat_side = sat_side_s3;

endmodule

// ===== design/rhc_div.sv =====
module rhc_div #(
	parameter int SIDE_W = 1
) (
	input  logic                       clk,
	input  logic [rhc_pkg::DIV_Q_W-1:0] ld,
	input  logic [rhc_pkg::DIV_N_W-1:0] num,
	input  logic [rhc_pkg::DIV_D_W-1:0] dvs,
	input  logic [SIDE_W-1:0]           side_in,
	output logic [rhc_pkg::DIV_Q_W-1:0] quo,
	output logic [SIDE_W-1:0]           side_out
);
	import rhc_pkg::*;

	// Inputs seen by each step.
	logic [DIV_D_W-1:0] rem_i  [DIV_Q_W];
	logic [DIV_Q_W-1:0] num_i  [DIV_Q_W];
	logic [DIV_D_W-1:0] dvs_i  [DIV_Q_W];
	logic [DIV_Q_W-1:0] quo_i  [DIV_Q_W];
	logic [SIDE_W-1:0]  side_i [DIV_Q_W];

	logic [DIV_Q_W-1:0] ge_c;
	logic [DIV_D_W-1:0] nrem_c [DIV_Q_W-1];

	// Registers behind each step; the last step keeps only quotient and sideband.
	logic [DIV_D_W-1:0] rem_s  [DIV_Q_W-1];
	logic [DIV_Q_W-1:0] num_s  [DIV_Q_W-1];
	logic [DIV_D_W-1:0] dvs_s  [DIV_Q_W-1];
	logic [DIV_Q_W-1:0] quo_s  [DIV_Q_W];
	logic [SIDE_W-1:0]  side_s [DIV_Q_W];

	for (genvar k = 0; k < DIV_Q_W; k++) begin : g_step
		logic [DIV_D_W:0] trial;

		if (k == 0) begin : g_first
			assign rem_i[k]  = num[DIV_N_W-1:DIV_Q_W];
			assign num_i[k]  = num[DIV_Q_W-1:0];
			assign dvs_i[k]  = dvs;
			assign quo_i[k]  = '0;
			assign side_i[k] = side_in;
		end else begin : g_next
			assign rem_i[k]  = rem_s[k-1];
			assign num_i[k]  = num_s[k-1];
			assign dvs_i[k]  = dvs_s[k-1];
			assign quo_i[k]  = quo_s[k-1];
			assign side_i[k] = side_s[k-1];
		end

		// One quotient bit: bring down the next numerator bit, subtract if it fits.
		assign trial   = {rem_i[k], num_i[k][DIV_Q_W-1]};
		assign ge_c[k] = trial >= {1'b0, dvs_i[k]};

		if (k < DIV_Q_W - 1) begin : g_rem
			logic [DIV_D_W-1:0] diff;

			// When the divisor fits, the difference is below the divisor, so the
			// low bits of the trial value are enough.
			assign diff      = trial[DIV_D_W-1:0] - dvs_i[k];
			assign nrem_c[k] = ge_c[k] ? diff : trial[DIV_D_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_Q_W; k++) begin
			if (ld[k]) begin
				quo_s[k]  <= {quo_i[k][DIV_Q_W-2:0], ge_c[k]};
				side_s[k] <= side_i[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_Q_W - 1; k++) begin
			if (ld[k]) begin
				rem_s[k] <= nrem_c[k];
				num_s[k] <= {num_i[k][DIV_Q_W-2:0], 1'b0};
				dvs_s[k] <= dvs_i[k];
			end
		end
	end

	assign quo      = quo_s[DIV_Q_W-1];
	assign side_out = side_s[DIV_Q_W-1];

endmodule

// ===== design/rhc_back.sv =====
module rhc_back (
	input  logic                        clk,
	input  logic                        ld,
	input  logic [rhc_pkg::DIV_Q_W-1:0] hue_quo,
	input  rhc_pkg::hue_side_t          hue_side,
	input  logic [rhc_pkg::DIV_Q_W-1:0] sat_quo,
	input  rhc_pkg::sat_side_t          sat_side,
	output rhc_pkg::hsv_t               res
);
	import rhc_pkg::*;

	logic        [HUE_W-1:0] hq_c;
	logic signed [HUE_W:0]   sum_c;
	logic signed [HUE_W:0]   wrap_c;
	hsv_t                    res_c;
	hsv_t                    res_s20;

	// The rounded sector quotient never exceeds one sector, so it fits the hue width.
	assign hq_c = hue_quo[HUE_W-1:0];

	always_comb begin
		if (hue_side.neg) begin
			sum_c = $signed({1'b0, hue_side.offset}) - $signed({1'b0, hq_c});
		end else begin
			sum_c = $signed({1'b0, hue_side.offset}) + $signed({1'b0, hq_c});
		end
		// Fold negative red-sector angles and a full turn back onto the circle.
		if (sum_c < 0) begin
			wrap_c = sum_c + $signed((HUE_W + 1)'(HUE_CIRCLE));
		end else if (sum_c >= $signed((HUE_W + 1)'(HUE_CIRCLE))) begin
			wrap_c = sum_c - $signed((HUE_W + 1)'(HUE_CIRCLE));
		end else begin
			wrap_c = sum_c;
		end

		res_c.hue        = hue_side.gray ? '0 : wrap_c[HUE_W-1:0];
		res_c.saturation = sat_side.black ? '0 : sat_quo[SAT_W-1:0];
		res_c.brightness = sat_side.brightness;
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			res_s20 <= res_c;
		end
	end

	assign res = res_s20;

endmodule

// ===== design/rgb_to_hsv_converter_core.sv =====
// RGB to HSV converter. Each beat on the pixel channel carries one 8-bit RGB
// pixel, and each beat on the hsv channel returns its hue (sixteenths of a
// degree, 0 to 5759), saturation (65535 means 1.0, rounded to nearest) and
// brightness (the largest channel). The block is a 20-stage pipeline: three
// stages find the largest and smallest channel, the sector and the rounding
// numerators, sixteen stages run two restoring dividers side by side at one
// quotient bit per stage, and a last stage places the hue on the circle and
// holds the result beat. While the hsv side is ready, a pixel is taken in every
// clock cycle, so the sustained rate is one pixel per cycle. A result is
// offered from the last stage and leaves on an edge where the hsv side is
// ready. Each stage keeps its own valid bit and loads whenever it is empty or
// its successor moves, so empty slots are squeezed out while the output stalls
// and new pixels keep entering until the pipeline is full. Pixels come out in
// the order they went in.
module rgb_to_hsv_converter_core (
	input logic       clk,
	input logic       arst_n,
	rhc_pixel_if.sink pixel,
	rhc_hsv_if.source hsv
);
	import rhc_pkg::*;

	localparam int NST = FRONT_STAGES + DIV_Q_W + 1;

	// Valid bit of every pipeline stage and the load enables derived from them.
	logic [NST-1:0] vld_q;
	logic [NST:0]   ld;

	logic [DIV_N_W-1:0] n_hue, n_sat;
	logic [DIV_D_W-1:0] d_hue, d_sat;
	hue_side_t          hue_side_f, hue_side_d;
	sat_side_t          sat_side_f, sat_side_d;
	logic [DIV_Q_W-1:0] hue_quo, sat_quo;
	hsv_t               res;

	// A stage may take a new beat when it is empty or when its own beat moves on.
	always_comb begin
		ld[NST] = hsv.ready;
		for (int k = NST - 1; k >= 0; k--) begin
			ld[k] = !vld_q[k] || ld[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ld[0]) begin
				vld_q[0] <= pixel.valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (ld[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign pixel.ready = ld[0];

	rhc_front u_front (
		.clk      (clk),
		.ld       (ld[FRONT_STAGES-1:0]),
		.pix      (pixel.data),
		.n_hue    (n_hue),
		.d_hue    (d_hue),
		.n_sat    (n_sat),
		.d_sat    (d_sat),
		.hue_side (hue_side_f),
		.sat_side (sat_side_f)
	);

	// Hue divider: (2*sector*|difference| + delta) / (2*delta).
	rhc_div #(
		.SIDE_W ($bits(hue_side_t))
	) u_div_hue (
		.clk      (clk),
		.ld       (ld[FRONT_STAGES +: DIV_Q_W]),
		.num      (n_hue),
		.dvs      (d_hue),
		.side_in  (hue_side_f),
		.quo      (hue_quo),
		.side_out (hue_side_d)
	);

	// Saturation divider: (2*full_scale*delta + max) / (2*max).
	rhc_div #(
		.SIDE_W ($bits(sat_side_t))
	) u_div_sat (
		.clk      (clk),
		.ld       (ld[FRONT_STAGES +: DIV_Q_W]),
		.num      (n_sat),
		.dvs      (d_sat),
		.side_in  (sat_side_f),
		.quo      (sat_quo),
		.side_out (sat_side_d)
	);

	rhc_back u_back (
		.clk      (clk),
		.ld       (ld[NST-1]),
		.hue_quo  (hue_quo),
		.hue_side (hue_side_d),
		.sat_quo  (sat_quo),
		.sat_side (sat_side_d),
		.res      (res)
	);

	assign hsv.valid = vld_q[NST-1];
	assign hsv.data  = res;

endmodule
